[rtl/lbpd_pkg.sv]
// Package with the types, constants and token decoder of the LZSS bit-packed decoder.
`timescale 1ns / 1ps

package lbpd_pkg;

	localparam int WINDOW_SIZE = 2048;
	localparam int WIN_AW = $clog2(WINDOW_SIZE);
	localparam logic [WIN_AW-1:0] WIN_START = 11'h7ef;
	localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_SIZE - 1);
	localparam logic [7:0] WIN_FILL = 8'h20;
	localparam logic [4:0] LIT_BITS = 5'd9;
	localparam logic [4:0] COPY_BITS = 5'd16;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_LIT,
		TOK_COPY
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t         kind;
		logic [7:0]        lit;
		logic [WIN_AW-1:0] pos;
		logic [3:0]        len;
		logic [15:0]       bits;
		logic [3:0]        cnt;
	} token_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIT,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic accept;
		logic emit_lit;
		logic emit_copy;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      copy_last;
		logic      clr_done;
		logic      last;
		logic      in_last;
		logic      can_emit;
	} dp_sts_t;

	// Shifts one stream byte into the token buffer, MSB first; at most one token completes.
	function automatic token_t decode_byte(logic [15:0] bits_in, logic [3:0] cnt_in,
			logic [7:0] byte_in);
		token_t     t;
		logic [15:0] b;
		logic [4:0]  c;
		t.kind = TOK_NONE;
		t.lit = '0;
		t.pos = '0;
		t.len = '0;
		b = bits_in;
		c = {1'b0, cnt_in};
		for (int k = 7; k >= 0; k--) begin
			b = {b[14:0], byte_in[k]};
			c = c + 5'd1;
			if (c == LIT_BITS && b[8]) begin
				t.kind = TOK_LIT;
				t.lit = b[7:0];
				b = '0;
				c = '0;
			end else if (c == COPY_BITS) begin
				t.kind = TOK_COPY;
				t.pos = b[WIN_AW+3:4];
				t.len = b[3:0];
				b = '0;
				c = '0;
			end
		end
		t.bits = b;
		t.cnt = c[3:0];
		return t;
	endfunction

endpackage

[rtl/lzss_bit_packed_decoder.sv]
// Top level of the LZSS bit-packed decoder with a 2048-byte history window.
`timescale 1ns / 1ps

// Each compressed byte is taken while the controller is idle. A byte that completes no token
// is done when it is taken, a byte that completes a literal holds it in lit_q and delivers it
// from the literal state into the output register once the output side can take it, and a byte
// that completes a copy of C+2 bytes delivers them at one beat per cycle while the output side
// does not stall, from the single read port of the window memory. The next input byte is taken
// while the last output beat still waits. After reset and after a byte marked last_byte, a
// clearing pass fills the window with 0x20; no input is taken during it.
module lzss_bit_packed_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lbpd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lbpd_pkg::out_item_t out_data
);
	import lbpd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	lbpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbpd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[rtl/lbpd_ctrl.sv]
// Controller state machine of the LZSS bit-packed decoder.
`timescale 1ns / 1ps

module lbpd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lbpd_pkg::dp_sts_t sts,
	output lbpd_pkg::dp_cmd_t cmd
);
	import lbpd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (sts.kind)
						TOK_LIT:  state_nxt = ST_LIT;
						TOK_COPY: state_nxt = ST_COPY;
						default:  state_nxt = sts.in_last ? ST_CLEAR : ST_IDLE;
					endcase
				end
			end
			ST_LIT: begin
				if (sts.can_emit) begin
					cmd.emit_lit = 1'b1;
					state_nxt = sts.last ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_COPY: begin
				if (sts.can_emit) begin
					cmd.emit_copy = 1'b1;
					if (sts.copy_last) begin
						state_nxt = sts.last ? ST_CLEAR : ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

[rtl/lbpd_datapath.sv]
// Datapath of the LZSS bit-packed decoder: token buffer, history window and output register.
`timescale 1ns / 1ps

module lbpd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lbpd_pkg::in_item_t  in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output lbpd_pkg::out_item_t out_data,
	input  lbpd_pkg::dp_cmd_t   cmd,
	output lbpd_pkg::dp_sts_t   sts
);
	import lbpd_pkg::*;

	logic [7:0]        win_mem [WINDOW_SIZE];
	logic [15:0]       bits_q;
	logic [3:0]        cnt_q;
	logic [WIN_AW-1:0] wp_q;
	logic [WIN_AW-1:0] clr_q;
	logic [WIN_AW-1:0] rptr_q;
	logic [4:0]        rem_q;
	logic [7:0]        lit_q;
	logic [7:0]        rdata_q;
	logic              fwd_q;
	logic              first_q;
	logic              last_q;
	logic              out_valid_q;
	out_item_t         out_q;

	token_t            tok;
	logic              emit;
	logic              rd_en;
	logic [WIN_AW-1:0] rd_addr;
	logic [7:0]        copy_byte;
	logic [7:0]        emit_byte;

	assign tok = decode_byte(bits_q, cnt_q, in_data.in_byte);
	assign emit = cmd.emit_lit | cmd.emit_copy;
	assign rd_en = (cmd.accept && tok.kind == TOK_COPY) || cmd.emit_copy;
	assign rd_addr = cmd.accept ? tok.pos : rptr_q;
	// A source one behind the write pointer takes the byte written in the previous beat from the output register.
	assign copy_byte = (fwd_q && !first_q) ? out_q.out_byte : rdata_q;
	assign emit_byte = cmd.emit_lit ? lit_q : copy_byte;

	assign sts.kind = tok.kind;
	assign sts.copy_last = (rem_q == 5'd0);
	assign sts.clr_done = (clr_q == WIN_LAST);
	assign sts.last = last_q;
	assign sts.in_last = in_data.last_byte;
	assign sts.can_emit = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			win_mem[clr_q] <= WIN_FILL;
		end else if (emit) begin
			win_mem[wp_q] <= emit_byte;
		end
		if (rd_en) begin
			rdata_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q <= '0;
			wp_q <= WIN_START;
			clr_q <= '0;
			first_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
				wp_q <= WIN_START;
				bits_q <= '0;
				cnt_q <= '0;
			end else if (cmd.accept) begin
				bits_q <= tok.bits;
				cnt_q <= tok.cnt;
				last_q <= in_data.last_byte;
				first_q <= 1'b1;
			end else if (emit) begin
				wp_q <= wp_q + 1'b1;
				first_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lit_q <= tok.lit;
			rptr_q <= tok.pos + 1'b1;
			rem_q <= {1'b0, tok.len} + 5'd1;
			fwd_q <= (tok.pos == wp_q - 1'b1);
		end else if (cmd.emit_copy) begin
			rptr_q <= rptr_q + 1'b1;
			rem_q <= rem_q - 5'd1;
		end
		if (emit) begin
			out_q.out_byte <= emit_byte;
			out_q.run_last <= cmd.emit_lit | sts.copy_last;
		end
	end

	a_no_emit_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && emit))
		else $error("window write collision between clear sweep and emitted beat");

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("beat emitted over an untaken output beat");

	a_rem_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_copy && rem_q != 5'd0) |=> (rem_q == $past(rem_q) - 5'd1))
		else $error("copy length counter did not step down");

	a_clear_resets_wp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (wp_q == WIN_START && cnt_q == 4'd0))
		else $error("clear sweep did not restore write pointer and bit count");

endmodule
